// File: rtl/field_oriented_drive_heading_hold_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading-hold drive block
// Implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef FIELD_ORIENTED_DRIVE_HEADING_HOLD_MACROS_SVH
`define FIELD_ORIENTED_DRIVE_HEADING_HOLD_MACROS_SVH
`define FODHH_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define FODHH_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/fodhh_pkg.sv
// ----------------------------------------------------------------------------
// fodhh_pkg
// Types, constants and the arctangent table for the heading-hold drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fodhh_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int XW = 34;
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [20:0] HOLD_LIMIT = 21'sd16384;

  localparam logic [1:0] REG_INVERT = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_KP = 2'd2;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] stick_turn;
    logic [15:0] speed_scale;
    logic [15:0] heading_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] turn_drive;
    logic hold_active;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cordic_t;

  function automatic logic signed [XW-1:0] atan_of(input logic [4:0] idx);
    logic signed [XW-1:0] r;
    case (idx)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10680350;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/fodhh_cell.sv
// ----------------------------------------------------------------------------
// fodhh_cell
// One CORDIC rotation step with a fixed shift, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fodhh_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  fodhh_pkg::cordic_t prev,
  output fodhh_pkg::cordic_t cur
);
  logic signed [fodhh_pkg::XW-1:0] dx;
  logic signed [fodhh_pkg::XW-1:0] dy;
  logic signed [fodhh_pkg::XW-1:0] ang;

  assign dx = prev.y >>> STEP;
  assign dy = prev.x >>> STEP;
  assign ang = fodhh_pkg::atan_of(5'(STEP));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= prev.valid;
    end
    cur.flip <= prev.flip;
    if (!prev.z[fodhh_pkg::XW-1]) begin
      cur.x <= prev.x - dx;
      cur.y <= prev.y + dy;
      cur.z <= prev.z - ang;
    end else begin
      cur.x <= prev.x + dx;
      cur.y <= prev.y - dy;
      cur.z <= prev.z + ang;
    end
  end
endmodule

// File: rtl/fodhh_chain.sv
// ----------------------------------------------------------------------------
// fodhh_chain
// Row of CORDIC cells giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fodhh_chain #(
  parameter int CORDIC_STEPS = fodhh_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [15:0] heading,
  output logic done,
  output logic signed [31:0] cos_v,
  output logic signed [31:0] sin_v
);
  fodhh_pkg::cordic_t link [CORDIC_STEPS+1];
  logic signed [fodhh_pkg::XW-1:0] z0;
  logic signed [fodhh_pkg::XW-1:0] xo;
  logic signed [fodhh_pkg::XW-1:0] yo;

  assign z0 = fodhh_pkg::XW'($signed({heading, 16'h0000}));

  always_comb begin
    link[0].valid = start;
    link[0].x = fodhh_pkg::CORDIC_X0;
    link[0].y = '0;
    if (z0 > 34'sd1073741824) begin
      link[0].z = z0 - 34'sd2147483648;
      link[0].flip = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      link[0].z = z0 + 34'sd2147483648;
      link[0].flip = 1'b1;
    end else begin
      link[0].z = z0;
      link[0].flip = 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    fodhh_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst(rst), .prev(link[i]), .cur(link[i+1])
    );
  end

  assign xo = link[CORDIC_STEPS].flip ? -link[CORDIC_STEPS].x : link[CORDIC_STEPS].x;
  assign yo = link[CORDIC_STEPS].flip ? -link[CORDIC_STEPS].y : link[CORDIC_STEPS].y;
  assign done = link[CORDIC_STEPS].valid;
  assign cos_v = xo[31:0];
  assign sin_v = yo[31:0];
endmodule

// File: rtl/field_oriented_drive_heading_hold.sv
// Path from accepted input to result: scale, hold, CORDIC cell row, multiply, sum.
// One transaction at a time; the next input is taken only when the FSM is idle again.
// A result waiting at the output does not block the next input.
// Reset (rst, synchronous): registers to 0 / 1638 / 4096, hold released, heading 0.
// ----------------------------------------------------------------------------
// field_oriented_drive_heading_hold
// Field-oriented drive step with heading hold and CORDIC rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "field_oriented_drive_heading_hold_macros.svh"
module field_oriented_drive_heading_hold #(
  parameter int CORDIC_STEPS = fodhh_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fodhh_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output fodhh_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_HOLD  = 6'b000100,
    S_ROT   = 6'b001000,
    S_MUL   = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t state;
  logic [2:0] invert_mask;
  logic [14:0] deadband;
  logic [15:0] kp_gain;
  logic hold_latched;
  logic [15:0] held_heading;
  fodhh_pkg::in_item_t item;
  logic signed [17:0] px, py, rot;
  logic signed [15:0] err;
  logic [1:0] mode;
  logic signed [15:0] turn;
  logic signed [31:0] cos_r, sin_r;
  logic signed [49:0] p_xc, p_ys, p_yc, p_xs;
  logic chain_start, chain_done;
  logic signed [31:0] cos_v, sin_v;
  logic out_free;

  localparam logic [1:0] M_TURN = 2'd0;
  localparam logic [1:0] M_HOLD = 2'd1;
  localparam logic [1:0] M_IDLE = 2'd2;

  function automatic logic signed [17:0] scale(input logic signed [15:0] a,
                                               input logic neg,
                                               input logic [15:0] sp);
    logic signed [16:0] v;
    logic signed [33:0] p;
    v = neg ? -17'(a) : 17'(a);
    p = v * $signed({1'b0, sp});
    return p[32:15];
  endfunction

  function automatic logic [17:0] mag(input logic signed [17:0] v);
    return v[17] ? 18'(-v) : 18'(v);
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [32:0] kp_prod;
  logic signed [20:0] kp_sh;
  logic signed [50:0] sum_x, sum_y;
  logic signed [15:0] herr;

  assign kp_prod = err * $signed({1'b0, kp_gain});
  assign kp_sh = kp_prod[32:12];
  assign sum_x = 51'(p_xc) + 51'(p_ys);
  assign sum_y = 51'(p_yc) - 51'(p_xs);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign chain_start = (state == S_HOLD);

  always_comb begin
    if (hold_latched) herr = $signed(held_heading - item.heading_angle);
    else herr = '0;
  end

  fodhh_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
    .clk(clk), .rst(rst), .start(chain_start), .heading(item.heading_angle),
    .done(chain_done), .cos_v(cos_v), .sin_v(sin_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      invert_mask <= 3'd0;
      deadband <= 15'd1638;
      kp_gain <= 16'd4096;
      hold_latched <= 1'b0;
      held_heading <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fodhh_pkg::REG_INVERT: invert_mask <= cfg_data[2:0];
          fodhh_pkg::REG_DEADBAND: deadband <= cfg_data[14:0];
          fodhh_pkg::REG_KP: kp_gain <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_SUM && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_SCALE;
        S_SCALE: state <= S_HOLD;
        S_HOLD: begin
          state <= S_ROT;
          if (mag(rot) > 18'(deadband)) begin
            hold_latched <= 1'b0;
          end else if (mag(px) > 18'(deadband) || mag(py) > 18'(deadband)) begin
            hold_latched <= 1'b1;
            if (!hold_latched) held_heading <= item.heading_angle;
          end else begin
            hold_latched <= 1'b0;
          end
        end
        S_ROT: if (chain_done) state <= S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) item <= in_data;
    if (state == S_SCALE) begin
      px <= scale(item.stick_x, invert_mask[0], item.speed_scale);
      py <= scale(item.stick_y, invert_mask[1], item.speed_scale);
      rot <= scale(item.stick_turn, invert_mask[2], item.speed_scale);
    end
    if (state == S_HOLD) begin
      if (mag(rot) > 18'(deadband)) mode <= M_TURN;
      else if (mag(px) > 18'(deadband) || mag(py) > 18'(deadband)) mode <= M_HOLD;
      else mode <= M_IDLE;
    end
    if (state == S_ROT) begin
      err <= herr;
      if (chain_done) begin
        cos_r <= cos_v;
        sin_r <= sin_v;
      end
    end
    if (state == S_MUL) begin
      p_xc <= px * cos_r;
      p_ys <= py * sin_r;
      p_yc <= py * cos_r;
      p_xs <= px * sin_r;
      case (mode)
        M_TURN: turn <= sat(21'(rot));
        M_HOLD: begin
          if (kp_sh > fodhh_pkg::HOLD_LIMIT) turn <= 16'sd16384;
          else if (kp_sh < -fodhh_pkg::HOLD_LIMIT) turn <= -16'sd16384;
          else turn <= kp_sh[15:0];
        end
        default: turn <= '0;
      endcase
    end
    if (state == S_SUM && out_free) begin
      out_data.robot_x <= sat(sum_x[50:30]);
      out_data.robot_y <= sat(sum_y[50:30]);
      out_data.turn_drive <= turn;
      out_data.hold_active <= hold_latched;
    end
  end

  `FODHH_ASSERT_NEXT(a_accept_scale, clk, rst, in_valid && !in_stall, state == S_SCALE)
  `FODHH_ASSERT_NOW(a_chain_in_rot, clk, rst, chain_done, state == S_ROT)
  `FODHH_ASSERT_NEXT(a_hold_limit, clk, rst, state == S_SUM && out_free && hold_latched && mode == M_HOLD, out_data.turn_drive <= 16'sd16384 && out_data.turn_drive >= -16'sd16384)
endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Heading-hold drive testbench
// Drives stick, speed and heading transactions through the valid/stall
// handshake with random gaps and stalls, predicts each result with an
// independent CORDIC and hold model, and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  localparam int STEPS = 16;
  localparam int WATCHDOG = 4000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  fodhh_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fodhh_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = fodhh_pkg::REG_INVERT;
  logic [15:0] cfg_data = '0;

  always #10 clk = ~clk;

  field_oriented_drive_heading_hold DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [2:0] inv_mask;
  logic [14:0] dead_band;
  logic [15:0] gain;
  logic hold_on;
  logic [15:0] hold_heading;

  fodhh_pkg::in_item_t pending_q[$];
  fodhh_pkg::out_item_t expected_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int long_hold = 0;
  bit done = 1'b0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10680350, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  task automatic rotate_vec(input logic [15:0] hdg, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(hdg) << 16;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint scaled(logic signed [15:0] raw, bit neg, longint spd);
    longint v;
    v = raw;
    if (neg) v = -v;
    return fshift(v * spd, 15);
  endfunction

  task automatic predict_drive(input fodhh_pkg::in_item_t it);
    longint spd, px, py, rot, turn, err, c, s;
    fodhh_pkg::out_item_t r;
    spd = it.speed_scale;
    px = scaled(it.stick_x, inv_mask[0], spd);
    py = scaled(it.stick_y, inv_mask[1], spd);
    rot = scaled(it.stick_turn, inv_mask[2], spd);
    if (abs_l(rot) > dead_band) begin
      hold_on = 1'b0;
      turn = sat(rot);
    end else if (abs_l(px) > dead_band || abs_l(py) > dead_band) begin
      if (!hold_on) begin
        hold_heading = it.heading_angle;
        hold_on = 1'b1;
      end
      err = longint'($signed(16'(hold_heading - it.heading_angle)));
      turn = fshift(err * longint'(gain), 12);
      if (turn > 16384) turn = 16384;
      if (turn < -16384) turn = -16384;
    end else begin
      hold_on = 1'b0;
      turn = 0;
    end
    rotate_vec(it.heading_angle, c, s);
    r.robot_x = 16'(sat(fshift(px * c + py * s, 30)));
    r.robot_y = 16'(sat(fshift(py * c - px * s, 30)));
    r.turn_drive = 16'(turn);
    r.hold_active = hold_on;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // driver
  int gap = 0;
  bit in_taken = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // still offered
      end else begin
        if (in_valid) begin
          void'(pending_q.pop_front());
          gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // accepted at rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) predict_drive(in_data);
  end

  // receiver stall and monitor
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        fodhh_pkg::out_item_t e;
        e = expected_q.pop_front();
        if (out_data.robot_x !== e.robot_x)
          report_mismatch("robot_x", out_data.robot_x, e.robot_x);
        if (out_data.robot_y !== e.robot_y)
          report_mismatch("robot_y", out_data.robot_y, e.robot_y);
        if (out_data.turn_drive !== e.turn_drive)
          report_mismatch("turn_drive", out_data.turn_drive, e.turn_drive);
        if (out_data.hold_active !== e.hold_active)
          report_mismatch("hold_active", out_data.hold_active, e.hold_active);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && $urandom_range(0, 2) == 0) stall_left = $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!done && idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic fodhh_pkg::in_item_t rand_item(bit held_seq);
    fodhh_pkg::in_item_t it;
    it.stick_x = 16'($urandom);
    it.stick_y = 16'($urandom);
    it.stick_turn = 16'($urandom);
    it.speed_scale = 16'($urandom_range(0, 32768));
    it.heading_angle = 16'($urandom);
    if ($urandom_range(0, 15) == 0) it.speed_scale = 16'($urandom);
    if (held_seq) begin
      it.stick_turn = 16'($signed($urandom_range(0, 2000)) - 1000);
      if ($urandom_range(0, 3) == 0) it.stick_x = 16'($urandom_range(0, 3000)) - 16'd1500;
    end
    return it;
  endfunction

  function automatic fodhh_pkg::in_item_t mk(int x, int y, int t, int sp, int h);
    fodhh_pkg::in_item_t it;
    it.stick_x = 16'(x);
    it.stick_y = 16'(y);
    it.stick_turn = 16'(t);
    it.speed_scale = 16'(sp);
    it.heading_angle = 16'(h);
    return it;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fodhh_pkg::REG_INVERT: inv_mask = val[2:0];
      fodhh_pkg::REG_DEADBAND: dead_band = val[14:0];
      fodhh_pkg::REG_KP: gain = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    int run;
    while (n > 0) begin
      run = $urandom_range(1, 30);
      for (int k = 0; k < run && n > 0; k++, n--)
        pending_q.push_back(rand_item($urandom_range(0, 4) != 0));
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 40)) @(posedge clk);
      while (pending_q.size() > 40) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    inv_mask = 3'd0;
    dead_band = 15'd1638;
    gain = 16'd4096;
    hold_on = 1'b0;
    hold_heading = 16'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_q.push_back(mk(0, 0, 0, 32768, 0));
    pending_q.push_back(mk(32767, 0, 0, 32768, 0));
    pending_q.push_back(mk(32767, 0, 0, 32768, 16384));
    pending_q.push_back(mk(-32768, -32768, 0, 32768, 32768));
    pending_q.push_back(mk(20000, 20000, 0, 65535, 49152));
    pending_q.push_back(mk(20000, 0, 100, 32768, 65535));
    pending_q.push_back(mk(0, 0, 32767, 32768, 100));
    pending_q.push_back(mk(0, 0, -32768, 65535, 100));
    pending_q.push_back(mk(5000, 0, 0, 32768, 1000));
    pending_q.push_back(mk(5000, 0, 0, 32768, 33768));
    pending_q.push_back(mk(1639, 0, 0, 32768, 12345));
    pending_q.push_back(mk(1638, 0, 0, 32768, 12345));
    pending_q.push_back(mk(0, 1639, 1638, 32768, 8192));
    pending_q.push_back(mk(0, 1639, 1639, 32768, 8192));
    pending_q.push_back(mk(32767, 32767, 0, 0, 3000));
    pending_q.push_back(mk(-32768, 32767, -1, 40000, 60000));
    drain();

    write_reg(fodhh_pkg::REG_INVERT, 16'h0007);
    write_reg(fodhh_pkg::REG_DEADBAND, 16'h0000);
    write_reg(fodhh_pkg::REG_KP, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    pending_q.push_back(mk(-32768, -32768, 0, 32768, 0));
    pending_q.push_back(mk(-32768, 100, 0, 32768, 32768));
    pending_q.push_back(mk(1, 1, -32768, 32768, 40000));
    pending_q.push_back(mk(0, 0, 0, 32768, 0));
    drain();
    random_phase(300);

    // long receiver hold while the sender keeps offering
    long_hold = 200;
    for (int k = 0; k < 20; k++) pending_q.push_back(rand_item(1'b1));
    drain();

    write_reg(fodhh_pkg::REG_DEADBAND, 16'h7FFF);
    write_reg(fodhh_pkg::REG_KP, 16'h0000);
    write_reg(fodhh_pkg::REG_INVERT, 16'h0002);
    random_phase(250);

    write_reg(fodhh_pkg::REG_DEADBAND, 16'd500);
    write_reg(fodhh_pkg::REG_KP, 16'd300);
    write_reg(fodhh_pkg::REG_INVERT, 16'h0005);
    random_phase(350);

    write_reg(fodhh_pkg::REG_DEADBAND, 16'd1638);
    write_reg(fodhh_pkg::REG_KP, 16'd4096);
    write_reg(fodhh_pkg::REG_INVERT, 16'h0000);
    random_phase(450);

    done = 1'b1;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: field_oriented_drive_heading_hold.f
+incdir+rtl
rtl/fodhh_pkg.sv
rtl/fodhh_cell.sv
rtl/fodhh_chain.sv
rtl/field_oriented_drive_heading_hold.sv
bench/tb.sv
